// File: hw/rtl/wshr_pkg.sv
// ----------------------------------------------------------------------------
// wshr_pkg
// Shared types and constants for the window stack hit test / raise core.
// ----------------------------------------------------------------------------
package wshr_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int COORD_BITS  = 12;

    // fixed field widths of the stream payload
    localparam int FIELD_W     = 12;
    localparam int ID_W        = 5;
    localparam int IN_TDATA_W  = 6 * FIELD_W;
    localparam int OUT_TDATA_W = ((ID_W + 7) / 8) * 8;

    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_CLICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_PLACE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] bottom;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] top;
        logic [ID_W-1:0]       id;
    } t_entry;

endpackage

// File: hw/rtl/window_stack_hit_test_raise_core.sv
// ----------------------------------------------------------------------------
// window_stack_hit_test_raise_core
// Z-ordered window stack in a one-port-read / one-port-write RAM, with
// top-down hit test and bring-to-front on click.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_axis: tuser = mode (0 load, 1 click), tdata carries the
//   rectangle bounds and the click point. A load appends a window on top with
//   the next id (ignored when the stack is full) and returns nothing. A click
//   returns one beat on m_axis: tuser = hit, tdata = window id (0 on miss).
//   A load is written to the RAM in its accepting cycle; s_axis_tready stays
//   high, so loads can follow back to back.
//   A click reads entries from the top down until one holds the point, then
//   moves each entry above the hit down one slot, writes the hit window on
//   top and posts the result; with no hit, or on an empty stack, the result
//   is a miss. The next beat is taken once the core is back in idle. The
//   RAM has one read port and one write port: one entry read and one
//   written per cycle.
//   The result sits in an output register; a load may be accepted while it
//   waits. A click that finishes while the previous result is still unread
//   holds in its final state until m_axis_tready frees the register.
//   Reset clears the window count and the output valid flag; RAM contents are
//   not cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module window_stack_hit_test_raise_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // left_x, bottom_y, right_x, top_y, point_x, point_y (lowest first)
    input  logic [wshr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // mode
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // window_id, zero padded
    output logic [wshr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // hit
    output logic                                m_axis_tuser
);

    localparam int FW = wshr_pkg::FIELD_W;
    localparam int CB = wshr_pkg::COORD_BITS;
    localparam int IW = wshr_pkg::IDX_W;
    localparam int CW = wshr_pkg::CNT_W;

    wshr_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_k, n_k;
    logic [CB-1:0]    r_px, n_px;
    logic [CB-1:0]    r_py, n_py;
    wshr_pkg::t_entry r_picked, n_picked;
    logic             r_hit, n_hit;
    logic             r_out_valid, n_out_valid;
    logic             r_out_hit, n_out_hit;
    logic [wshr_pkg::ID_W-1:0] r_out_id, n_out_id;

    wshr_pkg::t_entry r_mem [wshr_pkg::MAX_WINDOWS];
    wshr_pkg::t_entry r_rd_data;
    logic             mem_we, mem_re;
    logic [IW-1:0]    mem_wa, mem_ra;
    wshr_pkg::t_entry mem_wd;

    logic in_beat, out_free, rd_holds, near_top;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign rd_holds = (r_rd_data.left <= r_px) && (r_px <= r_rd_data.right) &&
                      (r_rd_data.bottom <= r_py) && (r_py <= r_rd_data.top);

    // true while there is still an entry above the current one to move down
    always_comb begin
        if (r_state == wshr_pkg::ST_SHIFT) begin
            near_top = (CW'(r_k) + CW'(2)) < r_count;
        end else begin
            near_top = (CW'(r_k) + CW'(1)) < r_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wshr_pkg::ST_IDLE: begin
                if (in_beat && s_axis_tuser == wshr_pkg::MODE_CLICK) begin
                    n_state = (r_count == '0) ? wshr_pkg::ST_DONE : wshr_pkg::ST_SEARCH;
                end
            end
            wshr_pkg::ST_SEARCH: begin
                if (rd_holds) begin
                    n_state = near_top ? wshr_pkg::ST_SHIFT : wshr_pkg::ST_PLACE;
                end else if (r_k == '0) begin
                    n_state = wshr_pkg::ST_DONE;
                end
            end
            wshr_pkg::ST_SHIFT: begin
                if (!near_top) n_state = wshr_pkg::ST_PLACE;
            end
            wshr_pkg::ST_PLACE: n_state = wshr_pkg::ST_DONE;
            wshr_pkg::ST_DONE: begin
                if (out_free) n_state = wshr_pkg::ST_IDLE;
            end
            default: n_state = wshr_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_count     = r_count;
        n_k         = r_k;
        n_px        = r_px;
        n_py        = r_py;
        n_picked    = r_picked;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_hit   = r_out_hit;
        n_out_id    = r_out_id;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = r_rd_data;
        mem_re      = 1'b0;
        mem_ra      = '0;
        case (r_state)
            wshr_pkg::ST_IDLE: begin
                if (in_beat) begin
                    if (s_axis_tuser == wshr_pkg::MODE_LOAD) begin
                        if (r_count < CW'(wshr_pkg::MAX_WINDOWS)) begin
                            mem_we        = 1'b1;
                            mem_wa        = IW'(r_count);
                            mem_wd.left   = CB'(s_axis_tdata[0*FW +: FW]);
                            mem_wd.bottom = CB'(s_axis_tdata[1*FW +: FW]);
                            mem_wd.right  = CB'(s_axis_tdata[2*FW +: FW]);
                            mem_wd.top    = CB'(s_axis_tdata[3*FW +: FW]);
                            mem_wd.id     = wshr_pkg::ID_W'(r_count + CW'(1));
                            n_count       = r_count + CW'(1);
                        end
                    end else begin
                        n_px  = CB'(s_axis_tdata[4*FW +: FW]);
                        n_py  = CB'(s_axis_tdata[5*FW +: FW]);
                        n_hit = 1'b0;
                        if (r_count != '0) begin
                            mem_re = 1'b1;
                            mem_ra = IW'(r_count - CW'(1));
                            n_k    = IW'(r_count - CW'(1));
                        end
                    end
                end
            end
            wshr_pkg::ST_SEARCH: begin
                if (rd_holds) begin
                    n_picked = r_rd_data;
                    n_hit    = 1'b1;
                    if (near_top) begin
                        mem_re = 1'b1;
                        mem_ra = r_k + IW'(1);
                    end
                end else if (r_k != '0) begin
                    mem_re = 1'b1;
                    mem_ra = r_k - IW'(1);
                    n_k    = r_k - IW'(1);
                end
            end
            wshr_pkg::ST_SHIFT: begin
                // entry k+1 has arrived, drop it into slot k
                mem_we = 1'b1;
                mem_wa = r_k;
                mem_wd = r_rd_data;
                if (near_top) begin
                    mem_re = 1'b1;
                    mem_ra = r_k + IW'(2);
                    n_k    = r_k + IW'(1);
                end
            end
            wshr_pkg::ST_PLACE: begin
                mem_we = 1'b1;
                mem_wa = IW'(r_count - CW'(1));
                mem_wd = r_picked;
            end
            wshr_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_out_id    = r_hit ? r_picked.id : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wshr_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_px      <= n_px;
        r_py      <= n_py;
        r_picked  <= n_picked;
        r_hit     <= n_hit;
        r_out_hit <= n_out_hit;
        r_out_id  <= n_out_id;
    end

    assign s_axis_tready = (r_state == wshr_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = wshr_pkg::OUT_TDATA_W'(r_out_id);
    assign m_axis_tuser  = r_out_hit;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(wshr_pkg::MAX_WINDOWS))
        else $error("window count above capacity");

    a_load_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && s_axis_tuser == wshr_pkg::MODE_LOAD &&
         r_count < CW'(wshr_pkg::MAX_WINDOWS))
        |=> r_count == $past(r_count) + CW'(1))
        else $error("load did not append a window");

    a_click_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != wshr_pkg::ST_IDLE) |=> r_count == $past(r_count))
        else $error("window count changed during a click");

    a_no_write_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wshr_pkg::ST_SEARCH) |-> !mem_we)
        else $error("RAM written during search");

    a_shift_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wshr_pkg::ST_SHIFT && mem_re) |-> mem_ra != mem_wa)
        else $error("shift read and write hit the same entry");

endmodule

// File: test/tb_window_stack_hit_test_raise_core.sv
// ----------------------------------------------------------------------------
// tb_window_stack_hit_test_raise_core
// Self-checking bench for the window stack hit test / raise core. A short
// directed table covers the empty stack, inclusive bounds, inverted
// rectangles, bring-to-front and loads past capacity. Random clicks follow,
// aimed mostly inside loaded windows. Results are checked against the table's
// typed values or a local z-order model, under random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_window_stack_hit_test_raise_core;

    localparam int RND_ITEMS   = 420;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 64;

    typedef struct packed {
        logic                      hit;
        logic [wshr_pkg::ID_W-1:0] id;
    } t_click_result;

    typedef struct {
        logic                            mode;
        logic [wshr_pkg::COORD_BITS-1:0] l, b, r, t, px, py;
        int                              reps;   // load rows: repeat count
        int                              step;   // offset added to the rectangle per repeat
        bit                              fixed;  // expected result typed into the row
        logic                            e_hit;
        logic [wshr_pkg::ID_W-1:0]       e_id;
    } t_row;

    logic                             i_clk;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // left_x, bottom_y, right_x, top_y, point_x, point_y (lowest first)
    logic [wshr_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // mode
    logic                             s_axis_tuser  = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // window_id, zero padded
    logic [wshr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    // hit
    logic                             m_axis_tuser;

    window_stack_hit_test_raise_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // z-order model: index 0 is the bottom
    wshr_pkg::t_entry z_stack [wshr_pkg::MAX_WINDOWS];
    int               z_count = 0;
    t_click_result    clicks_due [$];

    int          tx_idle_pct = 9;
    int          rx_idle_pct = 83;
    logic        hold_rx     = 1'b0;
    int          rnd_done    = 0;
    int unsigned cycle_count = 0;
    int          mismatches  = 0;
    int          n_loads = 0, n_dropped = 0, n_clicks = 0, n_hits = 0, n_miss = 0;

    t_row dir_rows [22];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, clicks_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0d: %s", cycle_count, what);
        mismatches++;
    endtask

    function automatic bit stack_append(input logic [wshr_pkg::COORD_BITS-1:0] l, b, r, t);
        if (z_count >= wshr_pkg::MAX_WINDOWS)
            return 1'b0;
        z_stack[z_count] = '{left: l, bottom: b, right: r, top: t,
                             id: wshr_pkg::ID_W'(z_count + 1)};
        z_count++;
        return 1'b1;
    endfunction

    // top-down search; the hit window moves to the top, the rest slide down
    function automatic t_click_result pick_and_raise(
            input logic [wshr_pkg::COORD_BITS-1:0] px, py);
        t_click_result    res;
        wshr_pkg::t_entry found;
        res = '0;
        for (int k = z_count - 1; k >= 0; k--) begin
            if (z_stack[k].left <= px && px <= z_stack[k].right &&
                z_stack[k].bottom <= py && py <= z_stack[k].top) begin
                found = z_stack[k];
                for (int i = k; i < z_count - 1; i++)
                    z_stack[i] = z_stack[i + 1];
                z_stack[z_count - 1] = found;
                res.hit = 1'b1;
                res.id  = found.id;
                return res;
            end
        end
        return res;
    endfunction

    // drive one beat, wait for acceptance, then update the model
    task automatic send_item(input logic mode,
                             input logic [wshr_pkg::COORD_BITS-1:0] l, b, r, t,
                             input logic [wshr_pkg::COORD_BITS-1:0] px, py,
                             input bit fixed, input logic e_hit,
                             input logic [wshr_pkg::ID_W-1:0] e_id);
        t_click_result res;
        bit            took_effect;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {py, px, t, r, b, l};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (mode == wshr_pkg::MODE_LOAD) begin
            took_effect = stack_append(l, b, r, t);
            if (took_effect)
                n_loads++;
            else
                n_dropped++;
        end else begin
            res = pick_and_raise(px, py);
            n_clicks++;
            if (res.hit)
                n_hits++;
            else
                n_miss++;
            if (fixed)
                clicks_due.push_back('{hit: e_hit, id: e_id});
            else
                clicks_due.push_back(res);
        end
    endtask

    always @(posedge i_clk)
        m_axis_tready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);

    // long receiver stall while the sender keeps going: the core must back up
    initial begin
        wait (rnd_done >= 320);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    always @(posedge i_clk) begin : result_check
        t_click_result                    want;
        logic [wshr_pkg::OUT_TDATA_W-1:0] want_data;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (clicks_due.size() == 0) begin
                report_mismatch($sformatf("result beat hit=%0b id=%0d with no click pending",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                want      = clicks_due.pop_front();
                want_data = '0;
                want_data[wshr_pkg::ID_W-1:0] = want.id;
                if (m_axis_tuser !== want.hit)
                    report_mismatch($sformatf("hit %0b, expected %0b", m_axis_tuser, want.hit));
                if (m_axis_tdata !== want_data)
                    report_mismatch($sformatf("window id %0d, expected %0d",
                                              m_axis_tdata, want_data));
            end
        end
    end

    initial begin : stimulus
        int                              roll;
        int                              pick;
        int                              off;
        wshr_pkg::t_entry                w;
        logic [wshr_pkg::COORD_BITS-1:0] rl, rb, rr, rt, px, py;

        dir_rows = '{
            // empty stack: both corners miss
            '{wshr_pkg::MODE_CLICK, 4095, 4095, 4095, 4095, 0, 0, 1, 0, 1, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 4095, 4095, 1, 0, 1, 0, 0},
            // window 1 in the corner; bounds inclusive
            '{wshr_pkg::MODE_LOAD, 0, 0, 5, 5, 4095, 4095, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 4095, 4095, 0, 0, 0, 0, 1, 0, 1, 1, 1},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 5, 5, 1, 0, 1, 1, 1},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 6, 5, 1, 0, 1, 0, 0},
            // inverted in x, then in y: never hit
            '{wshr_pkg::MODE_LOAD, 100, 0, 50, 4095, 0, 0, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 75, 10, 1, 0, 1, 0, 0},
            '{wshr_pkg::MODE_LOAD, 0, 200, 4095, 100, 0, 0, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 3, 150, 1, 0, 1, 0, 0},
            // window 4 in the far corner
            '{wshr_pkg::MODE_LOAD, 4090, 4090, 4095, 4095, 0, 0, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 4095, 4095, 1, 0, 1, 1, 4},
            // single-point window 5 over window 1, then raise window 1 above it
            '{wshr_pkg::MODE_LOAD, 3, 3, 3, 3, 0, 0, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 3, 3, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 2, 2, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 3, 3, 1, 0, 0, 0, 0},
            // overlapping diagonal chain fills the stack, one more load is dropped
            '{wshr_pkg::MODE_LOAD, 200, 300, 700, 900, 0, 0, 11, 300, 0, 0, 0},
            '{wshr_pkg::MODE_LOAD, 0, 0, 4095, 4095, 0, 0, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 4000, 4000, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 450, 550, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 700, 900, 1, 0, 0, 0, 0},
            '{wshr_pkg::MODE_CLICK, 0, 0, 0, 0, 3200, 3300, 1, 0, 0, 0, 0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                off = k * dir_rows[r].step;
                send_item(dir_rows[r].mode,
                          wshr_pkg::COORD_BITS'(dir_rows[r].l + off),
                          wshr_pkg::COORD_BITS'(dir_rows[r].b + off),
                          wshr_pkg::COORD_BITS'(dir_rows[r].r + off),
                          wshr_pkg::COORD_BITS'(dir_rows[r].t + off),
                          dir_rows[r].px, dir_rows[r].py,
                          dir_rows[r].fixed, dir_rows[r].e_hit, dir_rows[r].e_id);
            end
        end

        while (rnd_done < RND_ITEMS) begin
            if (rnd_done < RND_ITEMS / 3) begin
                tx_idle_pct = 9;
                rx_idle_pct = 83;
            end else if (rnd_done < 2 * RND_ITEMS / 3) begin
                tx_idle_pct = 83;
                rx_idle_pct = 9;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            roll = $urandom_range(0, 99);
            rl = wshr_pkg::COORD_BITS'($urandom);
            rb = wshr_pkg::COORD_BITS'($urandom);
            rr = wshr_pkg::COORD_BITS'($urandom);
            rt = wshr_pkg::COORD_BITS'($urandom);
            px = wshr_pkg::COORD_BITS'($urandom);
            py = wshr_pkg::COORD_BITS'($urandom);
            if (roll < 15) begin
                // stack is full by now: these loads are noise
                send_item(wshr_pkg::MODE_LOAD, rl, rb, rr, rt, px, py, 1'b0, 1'b0, '0);
                rnd_done++;
            end else begin
                if (roll >= 40 && z_count > 0) begin
                    pick = $urandom_range(0, z_count - 1);
                    w    = z_stack[pick];
                    if (w.left <= w.right && w.bottom <= w.top) begin
                        if ($urandom_range(0, 3) == 0) begin
                            // land on a corner
                            px = $urandom_range(0, 1) ? w.left : w.right;
                            py = $urandom_range(0, 1) ? w.bottom : w.top;
                        end else begin
                            px = wshr_pkg::COORD_BITS'($urandom_range(w.right, w.left));
                            py = wshr_pkg::COORD_BITS'($urandom_range(w.top, w.bottom));
                        end
                    end
                end
                send_item(wshr_pkg::MODE_CLICK, rl, rb, rr, rt, px, py, 1'b0, 1'b0, '0);
                rnd_done++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (clicks_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (clicks_due.size() != 0)
            report_mismatch($sformatf("%0d click results never arrived", clicks_due.size()));

        $display("covered %0d loads (%0d dropped on a full stack) and %0d clicks",
                 n_loads, n_dropped, n_clicks);
        $display("clicks: %0d hits with raise, %0d misses; %0d mismatches",
                 n_hits, n_miss, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/wshr_pkg.sv
hw/rtl/window_stack_hit_test_raise_core.sv
test/tb_window_stack_hit_test_raise_core.sv
